// ===== hw/rtl/b32d_pkg.sv =====
// b32d_pkg: types, constants and codes shared by the base32 stream decoder
// holds the result kind codes, the queue entry layout and the default queue depth
// no dependencies
package b32d_pkg;

   localparam int CHAR_W              = 8;
   localparam int BYTE_W              = 8;
   localparam int TOTAL_W             = 32;
   localparam int SYM_W               = 5;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_2 = 8'h32;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_7 = 8'h37;
   localparam logic [SYM_W-1:0]  DIGIT_BASE   = 5'd26;

   typedef enum logic [1:0] {
      KIND_DATA     = 2'd0,
      KIND_END_OK   = 2'd1,
      KIND_BAD_CHAR = 2'd2,
      KIND_BAD_LEN  = 2'd3
   } kind_type;

   // one accepted character's results: an optional byte, then an optional end result
   typedef struct packed {
      logic                byte_valid;
      logic [BYTE_W-1:0]   byte_value;
      logic                end_valid;
      kind_type            end_kind;
      logic [TOTAL_W-1:0]  total;
   } entry_type;

endpackage

// ===== hw/rtl/base32_stream_decoder_unit.sv =====
// base32_stream_decoder_unit: top level of the unpadded base32 stream decoder
// depends on b32d_pkg, b32d_front, b32d_queue and b32d_back
//
// takes one base32 character per item on req_ (tlast marks the end of a string) and returns
// decoded bytes and one end result per string on rsp_; an item is taken every cycle while
// the entry queue has room; the first result of a character passes the entry queue and the
// output register before it is offered on rsp_, and a second result of the same character follows it;
// the result port delivers one item per cycle while rsp_tready is high, so strings sustain one
// character per cycle; no clearing pass after reset
module base32_stream_decoder_unit #(
   parameter int QUEUE_DEPTH = b32d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            req_tvalid,
   output logic                                            req_tready,
   input  logic [b32d_pkg::CHAR_W-1:0]                     req_tdata,  // char_in
   input  logic                                            req_tlast,  // end_of_string
   output logic                                            rsp_tvalid,
   input  logic                                            rsp_tready,
   output logic [b32d_pkg::BYTE_W+b32d_pkg::TOTAL_W-1:0]   rsp_tdata,  // byte_value, byte_total
   output logic [1:0]                                      rsp_tuser,  // kind
   output logic                                            rsp_tlast   // last
);

   logic                  queue_full;
   logic                  push;
   b32d_pkg::entry_type   push_entry;
   logic                  pop;
   logic                  head_valid;
   b32d_pkg::entry_type   head_entry;

   b32d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   b32d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   b32d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hw/rtl/b32d_front.sv =====
// b32d_front: accepts characters, classifies them and runs the bit accumulator
// pushes one queue entry per item that gives any result
// depends on b32d_pkg
module b32d_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [b32d_pkg::CHAR_W-1:0]   req_tdata,  // char_in
   input  logic                          req_tlast,  // end_of_string
   input  logic                          queue_full,
   output logic                          push,
   output b32d_pkg::entry_type           push_entry
);

   logic [6:0]                     store_ff, store_in;
   logic [2:0]                     held_ff, held_in;
   logic [2:0]                     phase_ff, phase_in;
   logic                           skip_ff, skip_in;
   logic [b32d_pkg::TOTAL_W-1:0]   count_ff, count_in;

   logic                           accept;
   logic                           sym_ok;
   logic [b32d_pkg::SYM_W-1:0]     sym_v;
   logic [b32d_pkg::CHAR_W-1:0]    diff;
   logic [11:0]                    acc;
   logic [11:0]                    mask;
   logic [3:0]                     bits;
   logic [2:0]                     sh;
   logic                           emit;
   logic [b32d_pkg::BYTE_W-1:0]    byte_val;
   logic [b32d_pkg::TOTAL_W-1:0]   count_inc;
   logic [2:0]                     phase_next;
   logic                           len_ok;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      sym_ok = 1'b1;
      diff   = '0;
      sym_v  = '0;
      priority if (req_tdata >= b32d_pkg::CHAR_UPPER_A && req_tdata <= b32d_pkg::CHAR_UPPER_Z) begin
         diff  = req_tdata - b32d_pkg::CHAR_UPPER_A;
         sym_v = diff[b32d_pkg::SYM_W-1:0];
      end else if (req_tdata >= b32d_pkg::CHAR_LOWER_A && req_tdata <= b32d_pkg::CHAR_LOWER_Z) begin
         diff  = req_tdata - b32d_pkg::CHAR_LOWER_A;
         sym_v = diff[b32d_pkg::SYM_W-1:0];
      end else if (req_tdata >= b32d_pkg::CHAR_DIGIT_2 && req_tdata <= b32d_pkg::CHAR_DIGIT_7) begin
         diff  = req_tdata - b32d_pkg::CHAR_DIGIT_2;
         sym_v = diff[b32d_pkg::SYM_W-1:0] + b32d_pkg::DIGIT_BASE;
      end else begin
         sym_ok = 1'b0;
      end
   end

   always_comb begin
      acc        = {store_ff, sym_v};
      bits       = {1'b0, held_ff} + 4'd5;
      emit       = bits >= 4'd8;
      sh         = 3'(bits - 4'd8);
      byte_val   = 8'(acc >> sh);
      mask       = 12'((12'd1 << sh) - 12'd1);
      count_inc  = (count_ff == '1) ? count_ff : count_ff + 1'b1;
      phase_next = phase_ff + 3'd1;
      len_ok     = (phase_next == 3'd0) || (phase_next == 3'd2) || (phase_next == 3'd4)
                || (phase_next == 3'd5) || (phase_next == 3'd7);
   end

   always_comb begin
      store_in   = store_ff;
      held_in    = held_ff;
      phase_in   = phase_ff;
      skip_in    = skip_ff;
      count_in   = count_ff;
      push       = 1'b0;
      push_entry = '{byte_valid: 1'b0, byte_value: '0, end_valid: 1'b0,
                     end_kind: b32d_pkg::KIND_END_OK, total: count_ff};
      if (accept) begin
         priority if (skip_ff) begin
            if (req_tlast) begin
               skip_in = 1'b0;
            end
         end else if (!sym_ok) begin
            push                = 1'b1;
            push_entry.end_valid = 1'b1;
            push_entry.end_kind  = b32d_pkg::KIND_BAD_CHAR;
            skip_in             = !req_tlast;
         end else begin
            push                  = emit || req_tlast;
            push_entry.byte_valid = emit;
            push_entry.byte_value = byte_val;
            push_entry.end_valid  = req_tlast;
            push_entry.end_kind   = len_ok ? b32d_pkg::KIND_END_OK : b32d_pkg::KIND_BAD_LEN;
            push_entry.total      = emit ? count_inc : count_ff;
            store_in              = emit ? 7'(acc & mask) : acc[6:0];
            held_in               = emit ? sh : bits[2:0];
            count_in              = emit ? count_inc : count_ff;
            phase_in              = phase_next;
         end
         if (req_tlast) begin
            store_in = '0;
            held_in  = '0;
            phase_in = '0;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
         held_ff  <= '0;
         phase_ff <= '0;
         skip_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         store_ff <= store_in;
         held_ff  <= held_in;
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/b32d_queue.sv =====
// b32d_queue: short queue of result entries between front and back
// depends on b32d_pkg
module b32d_queue #(
   parameter int DEPTH = b32d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b32d_pkg::entry_type   push_entry,
   input  logic                  pop,
   output logic                  full,
   output logic                  head_valid,
   output b32d_pkg::entry_type   head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b32d_pkg::entry_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = mem_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[tail_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("item pushed into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("pop from empty queue");
`endif

endmodule

// ===== hw/rtl/b32d_back.sv =====
// b32d_back: unpacks queue entries into result items behind an output register
// depends on b32d_pkg
module b32d_back (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            head_valid,
   input  b32d_pkg::entry_type                             head_entry,
   output logic                                            pop,
   output logic                                            rsp_tvalid,
   input  logic                                            rsp_tready,
   output logic [b32d_pkg::BYTE_W+b32d_pkg::TOTAL_W-1:0]   rsp_tdata,  // byte_value, byte_total
   output logic [1:0]                                      rsp_tuser,  // kind
   output logic                                            rsp_tlast   // last
);

   logic                             valid_ff, valid_in;
   logic                             beat_ff, beat_in;
   logic                             load;
   logic [b32d_pkg::BYTE_W-1:0]      byte_ff, byte_in;
   logic [b32d_pkg::TOTAL_W-1:0]     total_ff, total_in;
   b32d_pkg::kind_type               kind_ff, kind_in;
   logic                             last_ff, last_in;

   assign load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      beat_in  = beat_ff;
      pop      = 1'b0;
      byte_in  = byte_ff;
      total_in = total_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      if (load && head_valid) begin
         valid_in = 1'b1;
         total_in = head_entry.total;
         if (head_entry.byte_valid && !beat_ff) begin
            byte_in = head_entry.byte_value;
            kind_in = b32d_pkg::KIND_DATA;
            last_in = 1'b0;
            if (head_entry.end_valid) begin
               beat_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end else begin
            byte_in = '0;
            kind_in = head_entry.end_kind;
            last_in = 1'b1;
            beat_in = 1'b0;
            pop     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      total_ff <= total_in;
      kind_ff  <= kind_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {total_ff, byte_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

`ifndef SYNTHESIS
   a_last_by_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (kind_ff != b32d_pkg::KIND_DATA)))
      else $error("last flag does not match result kind");
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && kind_ff != b32d_pkg::KIND_DATA) |-> (byte_ff == '0))
      else $error("end result carries a byte value");
`endif

endmodule

// ===== bench/testbench.sv =====
// testbench for base32_stream_decoder_unit: directed strings then random ones, with bursty input
// and a stalling receiver; a local decoder model predicts each result item and the monitor checks it
// depends on b32d_pkg and base32_stream_decoder_unit
`timescale 1ns / 1ps

module testbench;

   typedef struct {
      logic [b32d_pkg::CHAR_W-1:0] code;
      logic                        is_end;
   } char_item_type;

   typedef struct {
      logic [b32d_pkg::BYTE_W-1:0]  byte_value;
      b32d_pkg::kind_type           kind;
      logic [b32d_pkg::TOTAL_W-1:0] total;
      logic                         last;
   } decoded_result_type;

   typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_PERIODIC} ready_mode_type;

   localparam int STRING_ITEMS = 1300;

   logic                                          clock      = 1'b0;
   logic                                          reset      = 1'b1;
   logic                                          req_tvalid = 1'b0;
   logic                                          req_tready;
   logic [b32d_pkg::CHAR_W-1:0]                   req_tdata  = '0;   // char_in
   logic                                          req_tlast  = 1'b0; // end_of_string
   logic                                          rsp_tvalid;
   logic                                          rsp_tready = 1'b0;
   logic [b32d_pkg::BYTE_W+b32d_pkg::TOTAL_W-1:0] rsp_tdata;  // byte_value, byte_total
   logic [1:0]                                    rsp_tuser;  // kind
   logic                                          rsp_tlast;  // last

   char_item_type      pending_chars[$];
   decoded_result_type pending_results[$];
   int                 error_count = 0;

   // decoder model state
   logic [6:0]                   held_bits;
   logic [2:0]                   held_count;
   logic [2:0]                   string_phase;
   logic                         skipping;
   logic [b32d_pkg::TOTAL_W-1:0] bytes_decoded;

   int             burst_left = 0;
   int             gap_left   = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_left  = 0;
   int             tick       = 0;

   base32_stream_decoder_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // bit 5 set when the character is in the alphabet, low bits hold its value
   function automatic logic [5:0] symbol_of(logic [b32d_pkg::CHAR_W-1:0] code);
      if (code >= b32d_pkg::CHAR_UPPER_A && code <= b32d_pkg::CHAR_UPPER_Z)
         return {1'b1, 5'(code - b32d_pkg::CHAR_UPPER_A)};
      if (code >= b32d_pkg::CHAR_LOWER_A && code <= b32d_pkg::CHAR_LOWER_Z)
         return {1'b1, 5'(code - b32d_pkg::CHAR_LOWER_A)};
      if (code >= b32d_pkg::CHAR_DIGIT_2 && code <= b32d_pkg::CHAR_DIGIT_7)
         return {1'b1, 5'(code - b32d_pkg::CHAR_DIGIT_2) + b32d_pkg::DIGIT_BASE};
      return 6'd0;
   endfunction

   function automatic void clear_string_state();
      held_bits     = '0;
      held_count    = '0;
      string_phase  = '0;
      skipping      = 1'b0;
      bytes_decoded = '0;
   endfunction

   function automatic void expect_result(logic [b32d_pkg::BYTE_W-1:0] value,
                                         b32d_pkg::kind_type kind, logic last);
      decoded_result_type r;
      r.byte_value = value;
      r.kind       = kind;
      r.total      = bytes_decoded;
      r.last       = last;
      pending_results.push_back(r);
   endfunction

   function automatic void decode_char(logic [b32d_pkg::CHAR_W-1:0] code, logic is_end);
      logic [5:0]  sym;
      logic [11:0] acc;
      logic [3:0]  nbits;
      logic [3:0]  shift;
      if (skipping) begin
         if (is_end) clear_string_state();
         return;
      end
      sym = symbol_of(code);
      if (!sym[5]) begin
         expect_result('0, b32d_pkg::KIND_BAD_CHAR, 1'b1);
         if (is_end) clear_string_state();
         else skipping = 1'b1;
         return;
      end
      acc   = {held_bits, sym[4:0]};
      nbits = held_count + 4'd5;
      if (nbits >= 4'd8) begin
         shift = nbits - 4'd8;
         if (bytes_decoded != '1) bytes_decoded = bytes_decoded + 1'b1;
         expect_result(8'(acc >> shift), b32d_pkg::KIND_DATA, 1'b0);
         acc   = acc & ((12'd1 << shift) - 12'd1);
         nbits = shift;
      end
      held_bits    = acc[6:0];
      held_count   = nbits[2:0];
      string_phase = string_phase + 3'd1;
      if (is_end) begin
         expect_result('0, (string_phase inside {3'd0, 3'd2, 3'd4, 3'd5, 3'd7}) ?
                       b32d_pkg::KIND_END_OK : b32d_pkg::KIND_BAD_LEN, 1'b1);
         clear_string_state();
      end
   endfunction

   function automatic void note_failure(string msg);
      error_count++;
      if (error_count <= 10) $display("%0t: %s", $time, msg);
   endfunction

   // sender: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         clear_string_state();
      end else begin
         if (req_tvalid && req_tready) begin
            decode_char(req_tdata, req_tlast);
            void'(pending_chars.pop_front());
            if (burst_left > 0) burst_left--;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (burst_left == 0 && gap_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_chars.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_chars[0].code;
               req_tlast  <= pending_chars[0].is_end;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each result item and stalls on a changing pattern
   always @(posedge clock) begin
      decoded_result_type want;
      decoded_result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.byte_value = rsp_tdata[b32d_pkg::BYTE_W-1:0];
            got.total      = rsp_tdata[b32d_pkg::BYTE_W+b32d_pkg::TOTAL_W-1:b32d_pkg::BYTE_W];
            got.kind       = b32d_pkg::kind_type'(rsp_tuser);
            got.last       = rsp_tlast;
            if (pending_results.size() == 0) begin
               note_failure($sformatf("unexpected item: byte %h kind %s total %0d last %b",
                  got.byte_value, got.kind.name(), got.total, got.last));
            end else begin
               want = pending_results.pop_front();
               if (got.byte_value !== want.byte_value || got.kind !== want.kind ||
                   got.total !== want.total || got.last !== want.last)
                  note_failure($sformatf({"mismatch: expected byte %h kind %s total %0d last %b,",
                     " got byte %h kind %s total %0d last %b"},
                     want.byte_value, want.kind.name(), want.total, want.last,
                     got.byte_value, got.kind.name(), got.total, got.last));
            end
         end
         tick++;
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 150);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            READY_ALWAYS:   rsp_tready <= 1'b1;
            READY_HALF:     rsp_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE:   rsp_tready <= ($urandom_range(0, 3) == 0);
            default:        rsp_tready <= (tick % 3 != 0);
         endcase
      end
   end

   function automatic void add_item(logic [b32d_pkg::CHAR_W-1:0] code, logic is_end);
      char_item_type it;
      it.code   = code;
      it.is_end = is_end;
      pending_chars.push_back(it);
   endfunction

   function automatic void add_string(string s);
      for (int i = 0; i < s.len(); i++) add_item(s[i], i == s.len() - 1);
   endfunction

   function automatic logic [b32d_pkg::CHAR_W-1:0] random_valid_char();
      int v;
      v = $urandom_range(0, 31);
      if (v >= 26) return b32d_pkg::CHAR_DIGIT_2 + b32d_pkg::CHAR_W'(v - 26);
      return ($urandom_range(0, 1) ? b32d_pkg::CHAR_LOWER_A : b32d_pkg::CHAR_UPPER_A)
             + b32d_pkg::CHAR_W'(v);
   endfunction

   function automatic logic [b32d_pkg::CHAR_W-1:0] random_bad_char();
      logic [b32d_pkg::CHAR_W-1:0] c;
      logic [5:0]                  s;
      // sometimes a neighbour of the alphabet ranges, mostly any other code outside the alphabet
      case ($urandom_range(0, 3))
         0: begin
            case ($urandom_range(0, 5))
               0: c = b32d_pkg::CHAR_UPPER_A - 1'b1;
               1: c = b32d_pkg::CHAR_UPPER_Z + 1'b1;
               2: c = b32d_pkg::CHAR_LOWER_A - 1'b1;
               3: c = b32d_pkg::CHAR_LOWER_Z + 1'b1;
               4: c = b32d_pkg::CHAR_DIGIT_2 - 1'b1;
               default: c = b32d_pkg::CHAR_DIGIT_7 + 1'b1;
            endcase
         end
         default: begin
            do begin
               c = b32d_pkg::CHAR_W'($urandom_range(0, 255));
               s = symbol_of(c);
            end while (s[5]);
         end
      endcase
      return c;
   endfunction

   initial begin
      int count;
      int len;
      int bad_at;
      // directed strings
      add_string("AZ");
      add_string("az27");
      add_string("777");
      add_string("A@BC");
      add_item(8'hFF, 1'b1);
      add_string("77777777");
      add_string("A");
      count = pending_chars.size();
      while (count < STRING_ITEMS) begin
         case ($urandom_range(0, 9))
            0: begin
               // noise
               len = $urandom_range(1, 12);
               for (int i = 0; i < len; i++)
                  add_item(b32d_pkg::CHAR_W'($urandom_range(0, 255)), i == len - 1);
               count += len;
            end
            1, 2: begin
               // string broken by a bad character, possibly the last one
               len    = $urandom_range(1, 24);
               bad_at = $urandom_range(0, len - 1);
               for (int i = 0; i < len; i++)
                  add_item(i == bad_at ? random_bad_char() : random_valid_char(), i == len - 1);
               count += len;
            end
            default: begin
               len = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
               for (int i = 0; i < len; i++) add_item(random_valid_char(), i == len - 1);
               count += len;
            end
         endcase
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_chars.size() != 0 || pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
